/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while the active-low reset is asserted.
`define VBMM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define VBMM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `VBMM_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/vbmm_pkg.sv */
package vbmm_pkg;

    // Field widths of the request and response beats
    localparam int KIND_W       = 2;
    localparam int ADDR_W       = 16;
    localparam int LOAD_INDEX_W = 17;
    localparam int DATA_W       = 8;
    localparam int REGION_W     = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;

    // Parameter defaults
    localparam int PATTERN_ADDR_BITS_DEF = 17;
    localparam int NAMETABLE_DEPTH_DEF   = 4096;

    // Fixed geometry
    localparam int BUS_ADDR_W    = 14;
    localparam int PAT_RAW_W     = 17;
    localparam int NT_RAW_W      = 12;
    localparam int PALETTE_DEPTH = 32;
    localparam int PAL_IDX_W     = 5;

    localparam logic [5:0] PALETTE_PAGE  = 6'h3f;
    localparam logic [4:0] CHR_SIZE_MIN  = 5'd13;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_LOAD   = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    localparam logic [REGION_W-1:0] REGION_PATTERN   = 2'd0;
    localparam logic [REGION_W-1:0] REGION_NAMETABLE = 2'd1;
    localparam logic [REGION_W-1:0] REGION_PALETTE   = 2'd2;

    typedef enum logic [2:0] {
        MAPPER_NROM  = 3'd0,
        MAPPER_MMC1  = 3'd1,
        MAPPER_UXROM = 3'd2,
        MAPPER_AXROM = 3'd3
    } t_mapper;

    typedef enum logic [2:0] {
        MIRROR_VERTICAL    = 3'd0,
        MIRROR_HORIZONTAL  = 3'd1,
        MIRROR_SINGLE_LOW  = 3'd2,
        MIRROR_SINGLE_HIGH = 3'd3,
        MIRROR_FOUR_SCREEN = 3'd4
    } t_mirror;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAPPER_KIND    = 3'd0,
        CFG_CHR_WRITABLE   = 3'd1,
        CFG_CHR_SIZE_LOG2  = 3'd2,
        CFG_CHR_4K_MODE    = 3'd3,
        CFG_CHR_BANK_LOW   = 3'd4,
        CFG_CHR_BANK_HIGH  = 3'd5,
        CFG_MIRRORING_MODE = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ADDR_W-1:0]       address;
        logic [LOAD_INDEX_W-1:0] load_index;
        logic [DATA_W-1:0]       write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [REGION_W-1:0] region;
    } t_rsp;

    localparam logic [DATA_W-1:0] PALETTE_RESET [PALETTE_DEPTH] = '{
        8'h09, 8'h01, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h0D,
        8'h08, 8'h10, 8'h08, 8'h24, 8'h00, 8'h00, 8'h04, 8'h2C,
        8'h09, 8'h01, 8'h34, 8'h03, 8'h00, 8'h04, 8'h00, 8'h14,
        8'h08, 8'h3A, 8'h00, 8'h02, 8'h00, 8'h20, 8'h2C, 8'h08
    };

endpackage

/* hw/rtl/vbmm_req_if.sv */
interface vbmm_req_if;
    logic            valid;
    logic            ready;
    vbmm_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/vbmm_rsp_if.sv */
interface vbmm_rsp_if;
    logic            valid;
    logic            ready;
    vbmm_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/video_bus_memory_map_core.sv */
// Channel   Dir  Payload                                   Handshake
// i_req     in   kind, address, load_index, write_data     valid/ready
// o_rsp     out  read_data, region                         valid/ready
// i_cfg_*   in   index, data (7 registers)                 write enable only
//
// One beat per cycle sustained while o_rsp.ready is high; the response of an
// accepted request passes the registered RAM read, then the output register.
// Reset is synchronous, active low: clears control and configuration and loads the
// power-up palette; pattern and nametable RAMs keep whatever they hold.
// A stalled response holds in the output register; the access stage behind it
// keeps one more beat, so i_req.ready drops only when both are full or in reset.
module video_bus_memory_map_core #(
    parameter int PATTERN_ADDR_BITS = vbmm_pkg::PATTERN_ADDR_BITS_DEF,
    parameter int NAMETABLE_DEPTH   = vbmm_pkg::NAMETABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vbmm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [vbmm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    vbmm_req_if.sink                          i_req,
    vbmm_rsp_if.source                        o_rsp
);
    import vbmm_pkg::*;

    localparam int PAT_DEPTH = 1 << PATTERN_ADDR_BITS;
    localparam int NT_IDX_W  = $clog2(NAMETABLE_DEPTH);
    localparam logic [NT_RAW_W-1:0] NT_MASK = NT_RAW_W'(NAMETABLE_DEPTH - 1);
    localparam logic [4:0] PAT_BITS_MAX = 5'(PATTERN_ADDR_BITS);

    // Source of the byte a read returns, decided at acceptance
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_PAT  = 2'd1,
        SRC_NT   = 2'd2,
        SRC_PAL  = 2'd3
    } t_rd_src;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [2:0] r_mapper_kind;
    logic       r_chr_writable;
    logic [4:0] r_chr_size_log2;
    logic       r_chr_4k_mode;
    logic [4:0] r_chr_bank_low;
    logic [4:0] r_chr_bank_high;
    logic [2:0] r_mirroring_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_kind    <= MAPPER_NROM;
            r_chr_writable   <= 1'b0;
            r_chr_size_log2  <= CHR_SIZE_MIN;
            r_chr_4k_mode    <= 1'b0;
            r_chr_bank_low   <= 5'd0;
            r_chr_bank_high  <= 5'd0;
            r_mirroring_mode <= MIRROR_VERTICAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAPPER_KIND:    r_mapper_kind    <= i_cfg_data[2:0];
                CFG_CHR_WRITABLE:   r_chr_writable   <= i_cfg_data[0];
                CFG_CHR_SIZE_LOG2:  r_chr_size_log2  <= i_cfg_data[4:0];
                CFG_CHR_4K_MODE:    r_chr_4k_mode    <= i_cfg_data[0];
                CFG_CHR_BANK_LOW:   r_chr_bank_low   <= i_cfg_data[4:0];
                CFG_CHR_BANK_HIGH:  r_chr_bank_high  <= i_cfg_data[4:0];
                CFG_MIRRORING_MODE: r_mirroring_mode <= i_cfg_data[2:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Address decode of the incoming beat
    // ---------------------------------------------------------------
    logic [BUS_ADDR_W-1:0]        bus_addr;
    logic [REGION_W-1:0]          region;
    logic                         pat_mapped;
    logic [PAT_RAW_W-1:0]         pat_raw;
    logic [4:0]                   pat_bits;
    logic [PATTERN_ADDR_BITS-1:0] pat_mask;
    logic [PATTERN_ADDR_BITS-1:0] pat_idx;
    logic [PATTERN_ADDR_BITS-1:0] pat_addr;
    logic [NT_RAW_W-1:0]          nt_raw;
    logic [NT_RAW_W-1:0]          nt_masked;
    logic [NT_IDX_W-1:0]          nt_idx;
    logic [PAL_IDX_W-1:0]         pal_idx;

    assign bus_addr = i_req.payload.address[BUS_ADDR_W-1:0];

    always_comb begin
        if (!bus_addr[13]) begin
            region = REGION_PATTERN;
        end else if (bus_addr[13:8] == PALETTE_PAGE) begin
            region = REGION_PALETTE;
        end else begin
            region = REGION_NAMETABLE;
        end
    end

    // Cartridge banking: MMC1 places the bank number above the in-bank offset
    always_comb begin
        pat_mapped = 1'b1;
        pat_raw    = '0;
        unique case (r_mapper_kind) inside
            MAPPER_NROM, MAPPER_UXROM, MAPPER_AXROM: begin
                pat_raw = {4'd0, bus_addr[12:0]};
            end
            MAPPER_MMC1: begin
                if (!r_chr_4k_mode) begin
                    pat_raw = {r_chr_bank_low[4:1], bus_addr[12:0]};
                end else if (bus_addr[12]) begin
                    pat_raw = {r_chr_bank_high, bus_addr[11:0]};
                end else begin
                    pat_raw = {r_chr_bank_low, bus_addr[11:0]};
                end
            end
            default: begin
                pat_mapped = 1'b0;
            end
        endcase
    end

    // Clamp the size to the range the memory supports, then mask the index
    always_comb begin
        if (r_chr_size_log2 < CHR_SIZE_MIN) begin
            pat_bits = CHR_SIZE_MIN;
        end else if (r_chr_size_log2 > PAT_BITS_MAX) begin
            pat_bits = PAT_BITS_MAX;
        end else begin
            pat_bits = r_chr_size_log2;
        end
        for (int i = 0; i < PATTERN_ADDR_BITS; i++) begin
            pat_mask[i] = (5'(i) < pat_bits);
        end
    end

    assign pat_idx = pat_raw[PATTERN_ADDR_BITS-1:0] & pat_mask;

    // Nametable fold; the 0x3000 mirror is bit 12, which drops out here
    always_comb begin
        unique case (r_mirroring_mode)
            MIRROR_VERTICAL:    nt_raw = {1'b0, bus_addr[10:0]};
            MIRROR_HORIZONTAL:  nt_raw = {1'b0, bus_addr[11], bus_addr[9:0]};
            MIRROR_SINGLE_LOW:  nt_raw = {2'b00, bus_addr[9:0]};
            MIRROR_SINGLE_HIGH: nt_raw = {2'b11, bus_addr[9:0]};
            default:            nt_raw = bus_addr[11:0];
        endcase
    end

    assign nt_masked = nt_raw & NT_MASK;
    assign nt_idx    = nt_masked[NT_IDX_W-1:0];

    // Palette: the sprite backdrop entries alias the background ones
    always_comb begin
        pal_idx = bus_addr[4:0];
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
            pal_idx[4] = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Access control at acceptance
    // ---------------------------------------------------------------
    logic    req_acc;
    logic    is_read;
    logic    is_write;
    logic    is_load;
    logic    pat_we;
    logic    pat_re;
    logic    nt_we;
    logic    nt_re;
    logic    pal_we;
    logic    pal_re;
    t_rd_src rd_src;
    logic    out_go;

    logic                r_s1_valid;
    t_rd_src             r_s1_src;
    logic [REGION_W-1:0] r_s1_region;
    logic                r_out_valid;

    assign out_go      = !r_out_valid || o_rsp.ready;
    assign i_req.ready = i_rst_n && (!r_s1_valid || out_go);
    assign req_acc     = i_req.valid && i_req.ready;

    assign is_read  = (i_req.payload.kind == KIND_READ);
    assign is_write = (i_req.payload.kind == KIND_WRITE);
    assign is_load  = (i_req.payload.kind == KIND_LOAD);

    assign pat_we = req_acc && (is_load || (is_write && (region == REGION_PATTERN)
                                            && pat_mapped && r_chr_writable));
    assign pat_re = req_acc && is_read && (region == REGION_PATTERN) && pat_mapped;
    assign nt_we  = req_acc && is_write && (region == REGION_NAMETABLE);
    assign nt_re  = req_acc && is_read && (region == REGION_NAMETABLE);
    assign pal_we = req_acc && is_write && (region == REGION_PALETTE);
    assign pal_re = req_acc && is_read && (region == REGION_PALETTE);

    // A direct load takes the flat index instead of the banked one
    assign pat_addr = is_load ? i_req.payload.load_index[PATTERN_ADDR_BITS-1:0] : pat_idx;

    always_comb begin
        if (pat_re) begin
            rd_src = SRC_PAT;
        end else if (nt_re) begin
            rd_src = SRC_NT;
        end else if (pal_re) begin
            rd_src = SRC_PAL;
        end else begin
            rd_src = SRC_NONE;
        end
    end

    // ---------------------------------------------------------------
    // Stores: two synchronous RAMs and the palette file
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] r_pat_mem [PAT_DEPTH];
    logic [DATA_W-1:0] r_nt_mem  [NAMETABLE_DEPTH];
    logic [DATA_W-1:0] r_palette [PALETTE_DEPTH];
    logic [DATA_W-1:0] r_pat_rd;
    logic [DATA_W-1:0] r_nt_rd;
    logic [DATA_W-1:0] r_pal_rd;

    // Read data registers hold while the access stage stalls: no new read issues
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat_mem[pat_addr] <= i_req.payload.write_data;
        end
        if (pat_re) begin
            r_pat_rd <= r_pat_mem[pat_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            r_nt_mem[nt_idx] <= i_req.payload.write_data;
        end
        if (nt_re) begin
            r_nt_rd <= r_nt_mem[nt_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette <= PALETTE_RESET;
        end else if (pal_we) begin
            r_palette[pal_idx] <= i_req.payload.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_re) begin
            r_pal_rd <= r_palette[pal_idx];
        end
    end

    // ---------------------------------------------------------------
    // Access stage and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req_acc) begin
            r_s1_valid <= 1'b1;
        end else if (out_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1_src    <= rd_src;
            r_s1_region <= is_load ? REGION_PATTERN : region;
        end
    end

    logic [DATA_W-1:0]   n_read_data;
    logic [DATA_W-1:0]   r_out_read_data;
    logic [REGION_W-1:0] r_out_region;

    always_comb begin
        unique case (r_s1_src)
            SRC_PAT:  n_read_data = r_pat_rd;
            SRC_NT:   n_read_data = r_nt_rd;
            SRC_PAL:  n_read_data = r_pal_rd;
            default:  n_read_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_go) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Advance the access stage into the output register when it frees up
    always_ff @(posedge i_clk) begin
        if (out_go && r_s1_valid) begin
            r_out_read_data <= n_read_data;
            r_out_region    <= r_s1_region;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.payload.read_data = r_out_read_data;
    assign o_rsp.payload.region    = r_out_region;

endmodule

/* hw/rtl/vbmm_checker.sv */
`include "assert_macros.svh"

module vbmm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [vbmm_pkg::DATA_W-1:0]     i_rsp_read_data,
    input logic [vbmm_pkg::REGION_W-1:0]   i_rsp_region
);
    import vbmm_pkg::*;

    // A stalled response beat stays up and unchanged
    `VBMM_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response dropped while stalled")
    `VBMM_ASSERT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_read_data) && $stable(i_rsp_region), "stalled response changed")

    // Only the three decoded regions ever leave the block
    `VBMM_ASSERT_NEVER(a_region_legal, i_clk, i_rst_n, i_rsp_valid && i_rsp_region != REGION_PATTERN && i_rsp_region != REGION_NAMETABLE && i_rsp_region != REGION_PALETTE, "reserved region code")

    // A beat taken while no response is up comes out through the access stage and the output register
    `VBMM_ASSERT(a_latency, i_clk, i_rst_n, i_req_valid && i_req_ready && !i_rsp_valid |=> ##1 i_rsp_valid, "response missing")

    // Access stage full behind a stalled output: no more room
    `VBMM_ASSERT(a_backpressure, i_clk, i_rst_n, $past(i_req_valid && i_req_ready) && i_rsp_valid && !i_rsp_ready |-> !i_req_ready, "beat taken with both stages full")

endmodule

bind video_bus_memory_map_core vbmm_checker u_vbmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_data (o_rsp.payload.read_data),
    .i_rsp_region    (o_rsp.payload.region)
);

/* verif/video_bus_memory_map_core_tb.sv */
module video_bus_memory_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vbmm_pkg::*;

    // Geometry of the block as instantiated (default parameters)
    localparam int PAT_BITS     = 17;
    localparam int PAT_BITS_MIN = 13;
    localparam int PAT_DEPTH    = 1 << PAT_BITS;
    localparam int NT_DEPTH     = 4096;
    localparam int PAL_DEPTH    = 32;

    // Video bus decode boundaries
    localparam logic [13:0] NT_BASE   = 14'h2000;
    localparam logic [13:0] NT_MIRROR = 14'h3000;
    localparam logic [13:0] PAL_BASE  = 14'h3f00;
    localparam logic [13:0] BUS_TOP   = 14'h3fff;
    localparam logic [13:0] PAT_TOP   = 14'h1fff;
    localparam logic [13:0] NT_TOP    = 14'h3eff;

    // Codes outside the package enums: unmapped mappers, unknown mirroring,
    // and the one register index that has no register behind it
    localparam logic [2:0] MAPPER_NONE  = 3'd5;
    localparam logic [2:0] MAPPER_SPARE = 3'd7;
    localparam logic [2:0] MIRROR_SPARE = 3'd7;
    localparam logic [2:0] MIRROR_ODD   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

    localparam int HOT_SLOTS    = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 300000;
    localparam int REPORT_MAX   = 10;

    localparam logic [7:0] PAL_INIT_TABLE [PAL_DEPTH] = '{
        8'h09, 8'h01, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h0D,
        8'h08, 8'h10, 8'h08, 8'h24, 8'h00, 8'h00, 8'h04, 8'h2C,
        8'h09, 8'h01, 8'h34, 8'h03, 8'h00, 8'h04, 8'h00, 8'h14,
        8'h08, 8'h3A, 8'h00, 8'h02, 8'h00, 8'h20, 8'h2C, 8'h08
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    vbmm_req_if req_bus ();
    vbmm_rsp_if rsp_bus ();

    video_bus_memory_map_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the memory map: the three stores, which entries hold a
    // known byte, and the current cartridge/mirroring setup.
    // ------------------------------------------------------------------
    logic [7:0] pat_mem     [PAT_DEPTH];
    bit         pat_written [PAT_DEPTH];
    logic [7:0] nt_mem      [NT_DEPTH];
    bit         nt_written  [NT_DEPTH];
    logic [7:0] pal_mem     [PAL_DEPTH];

    logic [2:0] map_mapper;
    logic       map_writable;
    logic [4:0] map_size;
    logic       map_4k;
    logic [4:0] map_bank_lo;
    logic [4:0] map_bank_hi;
    logic [2:0] map_mirror;

    // Responses owed by the block, oldest first
    t_rsp access_results_due [$];

    // Recently used bus addresses, replayed as reads so most reads land
    // on entries that were recently accessed
    logic [15:0] hot_addr [HOT_SLOTS];

    int unsigned req_idle_pct;
    int unsigned rsp_idle_pct;
    int unsigned rsp_hold_request;

    int unsigned mismatch_count;
    int unsigned beats_sent;
    int unsigned reads_sent;
    int unsigned results_checked;
    int unsigned setups_applied;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // Address folding
    // ------------------------------------------------------------------

    // Cartridge banking for the pattern area; returns 0 when the mapper
    // leaves pattern memory unmapped.
    function automatic bit map_pattern(input logic [13:0] a, output logic [16:0] idx);
        int unsigned width;
        int unsigned raw;
        width = 32'(map_size);
        if (width < PAT_BITS_MIN) width = PAT_BITS_MIN;
        if (width > PAT_BITS) width = PAT_BITS;
        idx = '0;
        case (map_mapper)
            MAPPER_NROM, MAPPER_UXROM, MAPPER_AXROM: raw = 32'(a);
            MAPPER_MMC1: begin
                if (!map_4k)
                    raw = a + 32'h1000 * (map_bank_lo & 5'h1e);
                else if (a < 14'h1000)
                    raw = a + 32'h1000 * map_bank_lo;
                else
                    raw = (a - 32'h1000) + 32'h1000 * map_bank_hi;
            end
            default: return 1'b0;
        endcase
        idx = 17'(raw & ((32'd1 << width) - 1));
        return 1'b1;
    endfunction

    function automatic logic [11:0] fold_nametable(input logic [13:0] a);
        logic [13:0] v;
        v = a;
        if (v >= NT_MIRROR) v = v - 14'h1000;
        case (map_mirror)
            MIRROR_VERTICAL:    v = v & 14'h07ff;
            MIRROR_HORIZONTAL:  v = ((v >> 1) & 14'h0400) + (v & 14'h03ff);
            MIRROR_SINGLE_LOW:  v = v & 14'h03ff;
            MIRROR_SINGLE_HIGH: v = 14'h0c00 + (v & 14'h03ff);
            default: ;
        endcase
        return v[11:0];
    endfunction

    // Upper palette entries that are multiples of four share the backdrop
    // slots of the lower half.
    function automatic logic [4:0] fold_palette(input logic [13:0] a);
        logic [4:0] i;
        i = a[4:0];
        if ((i & 5'h13) == 5'h10) i = i & 5'h0f;
        return i;
    endfunction

    // ------------------------------------------------------------------
    // Access prediction: update the shadow stores and return the response
    // ------------------------------------------------------------------
    function automatic t_rsp predict_access(input t_req beat);
        t_rsp        r;
        logic [13:0] a;
        logic [16:0] pidx;
        logic [11:0] nidx;
        logic [4:0]  cidx;
        r = '0;
        a = beat.address[13:0];
        if (beat.kind == KIND_LOAD) begin
            pat_mem[beat.load_index]     = beat.write_data;
            pat_written[beat.load_index] = 1'b1;
            return r;
        end
        if (a < NT_BASE) begin
            r.region = REGION_PATTERN;
            if (map_pattern(a, pidx)) begin
                if (beat.kind == KIND_READ) begin
                    r.read_data = pat_mem[pidx];
                end else if (beat.kind == KIND_WRITE && map_writable) begin
                    pat_mem[pidx]     = beat.write_data;
                    pat_written[pidx] = 1'b1;
                end
            end
        end else if (a < PAL_BASE) begin
            r.region = REGION_NAMETABLE;
            nidx = fold_nametable(a);
            if (beat.kind == KIND_READ) begin
                r.read_data = nt_mem[nidx];
            end else if (beat.kind == KIND_WRITE) begin
                nt_mem[nidx]     = beat.write_data;
                nt_written[nidx] = 1'b1;
            end
        end else begin
            r.region = REGION_PALETTE;
            cidx = fold_palette(a);
            if (beat.kind == KIND_READ)
                r.read_data = pal_mem[cidx];
            else if (beat.kind == KIND_WRITE)
                pal_mem[cidx] = beat.write_data;
        end
        return r;
    endfunction

    // Turn a read of a never-written pattern or nametable entry into an
    // access that fills it: a direct load for pattern, a write for nametable.
    function automatic t_req avoid_unwritten_read(input t_req beat);
        t_req        r;
        logic [13:0] a;
        logic [16:0] pidx;
        r = beat;
        a = r.address[13:0];
        if (r.kind != KIND_READ) return r;
        if (a < NT_BASE) begin
            if (map_pattern(a, pidx) && !pat_written[pidx]) begin
                r.kind       = KIND_LOAD;
                r.load_index = pidx;
            end
        end else if (a < PAL_BASE) begin
            if (!nt_written[fold_nametable(a)]) r.kind = KIND_WRITE;
        end
        return r;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < PAL_DEPTH; i++) pal_mem[i] = PAL_INIT_TABLE[i];
        for (int i = 0; i < HOT_SLOTS; i++) hot_addr[i] = {2'b00, NT_BASE};
        map_mapper   = MAPPER_NROM;
        map_writable = 1'b0;
        map_size     = 5'd13;
        map_4k       = 1'b0;
        map_bank_lo  = '0;
        map_bank_hi  = '0;
        map_mirror   = MIRROR_VERTICAL;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned pct);
        if (pct == 0 || $urandom_range(99, 0) >= pct) return 0;
        if ($urandom_range(9, 0) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic t_req make_beat(input t_kind kind, input logic [15:0] address,
                                       input logic [16:0] load_index,
                                       input logic [7:0] write_data);
        t_req r;
        r.kind       = kind;
        r.address    = address;
        r.load_index = load_index;
        r.write_data = write_data;
        return r;
    endfunction

    function automatic t_req random_access();
        t_req        r;
        int unsigned pick;
        logic [13:0] low;
        r.load_index = 17'($urandom_range(32'h1ffff, 0));
        r.write_data = 8'($urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        if (pick < 45)      r.kind = KIND_READ;
        else if (pick < 80) r.kind = KIND_WRITE;
        else if (pick < 93) r.kind = KIND_LOAD;
        else                r.kind = KIND_UNUSED;
        if (r.kind == KIND_READ && $urandom_range(99, 0) < 60) begin
            r.address = hot_addr[$urandom_range(HOT_SLOTS - 1, 0)];
        end else begin
            pick = $urandom_range(99, 0);
            if (pick < 35)      low = 14'($urandom_range(PAT_TOP, 0));
            else if (pick < 75) low = 14'($urandom_range(NT_TOP, NT_BASE));
            else                low = 14'($urandom_range(BUS_TOP, PAL_BASE));
            // upper two bits are don't-care on the 14-bit bus
            r.address = {2'($urandom_range(3, 0)), low};
            hot_addr[$urandom_range(HOT_SLOTS - 1, 0)] = r.address;
        end
        return r;
    endfunction

    // Offer one beat and hold it until the block takes it. Valid stays up
    // afterwards so back-to-back beats need no extra edge.
    task automatic send_access(input t_req beat);
        t_req        item;
        t_rsp        want;
        int unsigned gap;
        item = avoid_unwritten_read(beat);
        want = predict_access(item);
        gap  = pick_gap(req_idle_pct);
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.payload <= item;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        access_results_due.push_back(want);
        beats_sent++;
        if (item.kind == KIND_READ) reads_sent++;
    endtask

    // Drop valid and wait for every owed response to come back
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (access_results_due.size() != 0) @(posedge i_clk);
    endtask

    // One register write per edge; the enable stays up across a sequence
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        case (idx)
            CFG_MAPPER_KIND:    map_mapper   = d[2:0];
            CFG_CHR_WRITABLE:   map_writable = d[0];
            CFG_CHR_SIZE_LOG2:  map_size     = d;
            CFG_CHR_4K_MODE:    map_4k       = d[0];
            CFG_CHR_BANK_LOW:   map_bank_lo  = d;
            CFG_CHR_BANK_HIGH:  map_bank_hi  = d;
            CFG_MIRRORING_MODE: map_mirror   = d[2:0];
            default: ;
        endcase
    endtask

    // Write the full register set while the block sits idle. A stray write
    // to the unused index rides along and must change nothing.
    task automatic apply_map_setup(input logic [4:0] mapper, input logic [4:0] writable,
                                   input logic [4:0] size_log2, input logic [4:0] four_k,
                                   input logic [4:0] bank_lo, input logic [4:0] bank_hi,
                                   input logic [4:0] mirror);
        drain_results();
        put_reg(CFG_MAPPER_KIND, mapper);
        put_reg(CFG_CHR_WRITABLE, writable);
        put_reg(CFG_CHR_SIZE_LOG2, size_log2);
        put_reg(CFG_SPARE, 5'($urandom_range(31, 0)));
        put_reg(CFG_CHR_4K_MODE, four_k);
        put_reg(CFG_CHR_BANK_LOW, bank_lo);
        put_reg(CFG_CHR_BANK_HIGH, bank_hi);
        put_reg(CFG_MIRRORING_MODE, mirror);
        i_cfg_we <= 1'b0;
        setups_applied++;
    endtask

    task automatic random_burst(input int unsigned count);
        repeat (count) send_access(random_access());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Palette comes out of reset with its power-up table; the upper
    // backdrop entries alias the lower ones and the area wraps every 32.
    task automatic test_palette_after_reset();
        send_access(make_beat(KIND_READ,  16'h3f00, '0, 8'h00));
        send_access(make_beat(KIND_READ,  16'h3f1f, '0, 8'h00));
        send_access(make_beat(KIND_READ,  16'hff10, '0, 8'h00));
        send_access(make_beat(KIND_READ,  16'h7fe4, '0, 8'h00));
        send_access(make_beat(KIND_WRITE, 16'h3f1c, '0, 8'hff));
        send_access(make_beat(KIND_READ,  16'h3f0c, '0, 8'h00));
        send_access(make_beat(KIND_WRITE, 16'h3f11, '0, 8'h00));
        send_access(make_beat(KIND_READ,  16'h3ff1, '0, 8'h00));
    endtask

    // Direct loads, read-only pattern memory, an unused kind, an unmapped
    // mapper that reads zero and ignores writes, then writable pattern memory.
    task automatic test_pattern_paths();
        send_access(make_beat(KIND_LOAD,   16'h0000, 17'h1ffff, 8'hff));
        send_access(make_beat(KIND_LOAD,   16'hffff, 17'h00000, 8'h5a));
        send_access(make_beat(KIND_READ,   16'h0000, '0, 8'h00));
        send_access(make_beat(KIND_WRITE,  16'h0000, '0, 8'h11));
        send_access(make_beat(KIND_READ,   16'h0000, '0, 8'h00));
        send_access(make_beat(KIND_LOAD,   16'h0000, 17'h01fff, 8'h80));
        send_access(make_beat(KIND_READ,   16'h1fff, '0, 8'h00));
        send_access(make_beat(KIND_UNUSED, 16'hc000, '0, 8'h33));
        apply_map_setup(5'(MAPPER_SPARE), 5'd1, 5'd13, 5'd0, 5'd0, 5'd0,
                        5'(MIRROR_VERTICAL));
        send_access(make_beat(KIND_READ,   16'h0000, '0, 8'h00));
        send_access(make_beat(KIND_WRITE,  16'h0000, '0, 8'h22));
        send_access(make_beat(KIND_LOAD,   16'h0000, 17'h00000, 8'h77));
        apply_map_setup(5'(MAPPER_NROM), 5'd1, 5'd13, 5'd0, 5'd0, 5'd0,
                        5'(MIRROR_VERTICAL));
        send_access(make_beat(KIND_READ,   16'h0000, '0, 8'h00));
        send_access(make_beat(KIND_WRITE,  16'h0000, '0, 8'h99));
        send_access(make_beat(KIND_READ,   16'h0000, '0, 8'h00));
    endtask

    // Vertical folding plus the 0x3000 mirror of the nametable area
    task automatic test_nametable_fold();
        send_access(make_beat(KIND_WRITE,  16'h2000, '0, 8'hc3));
        send_access(make_beat(KIND_READ,   16'h2800, '0, 8'h00));
        send_access(make_beat(KIND_READ,   16'h3000, '0, 8'h00));
        send_access(make_beat(KIND_WRITE,  16'h3eff, '0, 8'h3c));
        send_access(make_beat(KIND_READ,   16'h26ff, '0, 8'h00));
    endtask

    // Sweep mappers, bank extremes, pattern sizes (in range, clamped low
    // and high) and every mirroring mode, with and without idling.
    task automatic test_random_setups();
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        apply_map_setup(5'(MAPPER_NROM), 5'd1, 5'd13, 5'd0, 5'd0, 5'd0,
                        5'(MIRROR_VERTICAL));
        random_burst(80);

        req_idle_pct = 25;
        rsp_idle_pct = 20;
        apply_map_setup(5'(MAPPER_MMC1), 5'd1, 5'd17, 5'd0, 5'd31, 5'd0,
                        5'(MIRROR_HORIZONTAL));
        random_burst(80);

        apply_map_setup(5'(MAPPER_MMC1), 5'd1, 5'd17, 5'd1, 5'd0, 5'd31,
                        5'(MIRROR_SINGLE_LOW));
        random_burst(80);

        req_idle_pct = 50;
        rsp_idle_pct = 10;
        apply_map_setup(5'(MAPPER_MMC1), 5'd0, 5'd15, 5'd1, 5'($urandom_range(31, 0)),
                        5'($urandom_range(31, 0)), 5'(MIRROR_SINGLE_HIGH));
        random_burst(70);

        req_idle_pct = 10;
        rsp_idle_pct = 40;
        // size below the floor clamps to 8K
        apply_map_setup(5'(MAPPER_UXROM), 5'd1, 5'd5, 5'd0, 5'd0, 5'd0,
                        5'(MIRROR_FOUR_SCREEN));
        random_burst(70);

        // upper data bits set on narrow registers; size above the ceiling
        apply_map_setup({2'b11, MAPPER_AXROM}, 5'b11111, 5'd25, 5'b11110, 5'd0, 5'd0,
                        {2'b10, MIRROR_SPARE});
        random_burst(70);

        req_idle_pct = 20;
        rsp_idle_pct = 20;
        apply_map_setup(5'(MAPPER_NONE), 5'd1, 5'd16, 5'd1, 5'd3, 5'd4, 5'(MIRROR_ODD));
        random_burst(60);

        repeat (2) begin
            apply_map_setup(5'($urandom_range(7, 0)), 5'($urandom_range(1, 0)),
                            5'($urandom_range(31, 0)), 5'($urandom_range(1, 0)),
                            5'($urandom_range(31, 0)), 5'($urandom_range(31, 0)),
                            5'($urandom_range(7, 0)));
            random_burst(60);
        end
    endtask

    // Hold the response side off long enough for the block to fill and
    // stall its input, keep offering beats meanwhile, pause the sender
    // until everything owed has come back, then send with gaps on both sides.
    task automatic test_backpressure();
        apply_map_setup(5'(MAPPER_MMC1), 5'd1, 5'd17, 5'd1, 5'd7, 5'd24,
                        5'(MIRROR_HORIZONTAL));
        req_idle_pct     = 0;
        rsp_idle_pct     = 0;
        rsp_hold_request = 150;
        random_burst(30);
        drain_results();
        req_idle_pct = 30;
        rsp_idle_pct = 30;
        random_burst(30);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, plus long holds on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        stall_left    = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_request != 0) begin
                stall_left       = rsp_hold_request;
                rsp_hold_request = 0;
            end else if (stall_left == 0 && i_rst_n) begin
                stall_left = pick_gap(rsp_idle_pct);
            end
            if (stall_left != 0 || !i_rst_n) begin
                if (stall_left != 0) stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response checking: each accepted beat against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] ERROR: %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (access_results_due.size() == 0) begin
                flag_mismatch($sformatf("response with none owed: read_data %02h region %0d",
                                        rsp_bus.payload.read_data, rsp_bus.payload.region));
            end else begin
                want = access_results_due.pop_front();
                results_checked++;
                if (rsp_bus.payload.read_data !== want.read_data)
                    flag_mismatch($sformatf("read_data: expected %02h, got %02h",
                                            want.read_data, rsp_bus.payload.read_data));
                if (rsp_bus.payload.region !== want.region)
                    flag_mismatch($sformatf("region: expected %0d, got %0d",
                                            want.region, rsp_bus.payload.region));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d responses still owed",
                 cycle_count, access_results_due.size());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_count   = 0;
        beats_sent       = 0;
        reads_sent       = 0;
        results_checked  = 0;
        setups_applied   = 0;
        rsp_hold_request = 0;
        req_idle_pct     = 20;
        rsp_idle_pct     = 20;
        reset_shadow();

        // drive every input to a known value with reset asserted, then release reset
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        req_bus.valid   <= 1'b0;
        req_bus.payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_palette_after_reset();
        test_pattern_paths();
        test_nametable_fold();
        test_random_setups();
        test_backpressure();

        // let the pipeline settle after the last response
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats (%0d reads) over %0d register setups;",
                 beats_sent, reads_sent, setups_applied);
        $display("checked %0d responses in %0d cycles.", results_checked, cycle_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/vbmm_pkg.sv
hw/rtl/vbmm_req_if.sv
hw/rtl/vbmm_rsp_if.sv
hw/rtl/video_bus_memory_map_core.sv
hw/rtl/vbmm_checker.sv
verif/video_bus_memory_map_core_tb.sv
